// ===== rtl/calendar_date_add_days_defines.svh =====
// assertion macros shared by the checker
`ifndef CALENDAR_DATE_ADD_DAYS_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DADD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date add checker: same-cycle rule violated");

// next-cycle implication, also checked across reset
`define DADD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("date add checker: next-cycle rule violated");

`endif

// ===== rtl/dadd_pkg.sv =====
package dadd_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_ZERO     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STEP,
    BK_ZJ,
    BK_ZS,
    BK_RESULT
  } back_state_t;

  localparam logic [11:0] MAX_YEAR = 12'd2100;
  localparam logic [3:0]  MONTHS   = 4'd12;

  // leap year test; y / 100 by reciprocal multiply, exact for 12-bit years
  function automatic logic leap_of(input logic [11:0] y);
    logic [22:0] prod;
    logic [5:0]  q;
    logic [11:0] r;
    prod = 23'(y) * 23'(11'd1311);
    q    = prod[22:17];
    r    = y - 12'(13'(q) * 13'd100);
    return ((y[1:0] == 2'b00) && (r != 12'd0)) || ((r == 12'd0) && (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // (13 * (hm + 1)) / 5 with january and february counted as months 13 and 14
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      default: t = 6'd33;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/dadd_front.sv =====
module dadd_front #(
  parameter int CNT_W = 16,
  parameter int DAY_W = CNT_W + 1
) (
  input  logic [4:0]       start_day,
  input  logic [3:0]       start_month,
  input  logic [11:0]      start_year,
  input  logic [15:0]      days_to_add,
  output dadd_pkg::status_t status,
  output logic [DAY_W-1:0] day,
  output logic [3:0]       month,
  output logic [11:0]      year,
  output logic             leap
);

  logic [CNT_W-1:0] n;
  logic             bad;

  always_comb begin
    n    = days_to_add[CNT_W-1:0];
    leap = dadd_pkg::leap_of(start_year);
    bad  = (start_year > dadd_pkg::MAX_YEAR) || (start_month == 4'd0) ||
           (start_month > dadd_pkg::MONTHS) || (start_day == 5'd0) ||
           (start_day > dadd_pkg::month_len(start_month, leap));
    month = start_month;
    year  = start_year;
    priority if (bad) begin
      status = dadd_pkg::ST_BAD_DATE;
      day    = DAY_W'(start_day);
    end else if (n == '0) begin
      status = dadd_pkg::ST_ZERO;
      day    = DAY_W'(start_day);
    end else begin
      status = dadd_pkg::ST_OK;
      day    = DAY_W'(start_day) + DAY_W'(n);
    end
  end

endmodule

// ===== rtl/dadd_queue.sv =====
module dadd_queue #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== rtl/dadd_back.sv =====
module dadd_back #(
  parameter int DAY_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  dadd_pkg::status_t q_status,
  input  logic [DAY_W-1:0]  q_day,
  input  logic [3:0]        q_month,
  input  logic [11:0]       q_year,
  input  logic              q_leap,
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        status,
  output logic [4:0]        new_day,
  output logic [3:0]        new_month,
  output logic [11:0]       new_year,
  output logic [2:0]        weekday
);

  dadd_pkg::back_state_t state, state_next;

  dadd_pkg::status_t st;
  logic [DAY_W-1:0]  day;
  logic [3:0]        m;
  logic [11:0]       y;
  logic              leap;
  logic [4:0]        len;
  logic              over;

  // weekday pipeline
  logic [11:0] zhy;
  logic [5:0]  zj;
  logic [5:0]  zmt;
  logic        zneg;
  logic [8:0]  zs;

  logic [11:0] hy;
  logic [22:0] jprod;
  logic [6:0]  k;
  logic [9:0]  s_sum;
  logic [20:0] qprod;
  logic [5:0]  q7;
  logic [2:0]  wd;

  logic out_valid;
  logic load_out;

  assign len   = dadd_pkg::month_len(m, leap);
  assign over  = (day > DAY_W'(len));
  assign q_pop = (state == dadd_pkg::BK_IDLE) && q_valid;
  assign empty = !out_valid;

  always_comb begin
    hy    = (m < 4'd3) ? y - 12'd1 : y;
    jprod = 23'(hy) * 23'(11'd1311);
    k     = 7'(zhy - 12'(13'(zj) * 13'd100));
    if (zneg) begin
      s_sum = 10'(day[4:0]) + 10'(zmt) + 10'd117;
    end else begin
      s_sum = 10'(day[4:0]) + 10'(zmt) + 10'(k) + 10'(k[6:2]) + 10'(zj[5:2]) +
              10'(zj) * 10'd5;
    end
    qprod = 21'(zs) * 21'(12'd2341);
    q7    = qprod[19:14];
    wd    = 3'(zs - 9'(q7) * 9'd7);
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      dadd_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_status == dadd_pkg::ST_OK) ? dadd_pkg::BK_STEP
                                                     : dadd_pkg::BK_RESULT;
        end
      end
      dadd_pkg::BK_STEP: begin
        if (!over) begin
          state_next = dadd_pkg::BK_ZJ;
        end
      end
      dadd_pkg::BK_ZJ: state_next = dadd_pkg::BK_ZS;
      dadd_pkg::BK_ZS: state_next = dadd_pkg::BK_RESULT;
      dadd_pkg::BK_RESULT: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = dadd_pkg::BK_IDLE;
        end
      end
      default: state_next = dadd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dadd_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      st   <= q_status;
      day  <= q_day;
      m    <= q_month;
      y    <= q_year;
      leap <= q_leap;
    end else begin
      // leap is registered from the year, so it trails a year change; only january sees the stale value
      leap <= dadd_pkg::leap_of(y);
      if (state == dadd_pkg::BK_STEP && over) begin
        day <= day - DAY_W'(len);
        if (m == dadd_pkg::MONTHS) begin
          m <= 4'd1;
          y <= y + 12'd1;
        end else begin
          m <= m + 4'd1;
        end
      end
    end
    if (state == dadd_pkg::BK_ZJ) begin
      zhy  <= hy;
      zj   <= jprod[22:17];
      zmt  <= dadd_pkg::month_term(m);
      zneg <= (m < 4'd3) && (y == 12'd0);
    end
    if (state == dadd_pkg::BK_ZS) begin
      zs <= s_sum[8:0];
    end
    if (load_out) begin
      status    <= st;
      new_day   <= day[4:0];
      new_month <= m;
      new_year  <= y;
      weekday   <= (st == dadd_pkg::ST_OK) ? wd : 3'd0;
    end
  end

endmodule

// ===== rtl/calendar_date_add_days.sv =====
// calendar date advance with weekday
//
// input channel: a request carries start_day, start_month, start_year and
// days_to_add; it is taken on a rising edge with push high and full low.
// result channel: while empty is low the oldest result sits on status,
// new_day, new_month, new_year and weekday; pop high takes it.
// status 0 is a good advance, 1 a bad starting date, 2 a zero day count;
// rejected requests echo the start date with weekday 0.
// only the low COUNT_WIDTH bits of days_to_add (at most 16) are counted.
// the back end takes one month step per month boundary crossed, then works
// out the weekday; rejected requests skip both and go straight to the result;
// up to roughly 2160 month steps for the largest count. one request is
// in the back end at a time, so throughput is set by that month-step loop.
// a two-entry queue sits between the checking front end and the back end,
// so up to two more requests are taken while one is worked on.
// when the receiver stalls the finished result holds in the output
// register and the back end waits with the next one ready.
// reset (rst, synchronous) empties the queue and the output; no clearing.
module calendar_date_add_days #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [11:0] start_year,
  input  logic [15:0] days_to_add,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  status,
  output logic [4:0]  new_day,
  output logic [3:0]  new_month,
  output logic [11:0] new_year,
  output logic [2:0]  weekday
);

  // counted bits of the day count, and the width of day plus count
  localparam int CNT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
  localparam int DAY_W = CNT_W + 1;
  // queue entry: status, day, month, year, leap flag of the start year
  localparam int QW    = 2 + DAY_W + 4 + 12 + 1;

  dadd_pkg::status_t f_status;
  logic [DAY_W-1:0]  f_day;
  logic [3:0]        f_month;
  logic [11:0]       f_year;
  logic              f_leap;

  logic [QW-1:0]     q_wdata, q_rdata;
  logic              q_valid, q_pop;
  dadd_pkg::status_t q_status;
  logic [DAY_W-1:0]  q_day;
  logic [3:0]        q_month;
  logic [11:0]       q_year;
  logic              q_leap;

  // front end checks the date and adds the count to the day
  dadd_front #(
    .CNT_W (CNT_W),
    .DAY_W (DAY_W)
  ) u_front (
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .days_to_add (days_to_add),
    .status      (f_status),
    .day         (f_day),
    .month       (f_month),
    .year        (f_year),
    .leap        (f_leap)
  );

  assign q_wdata = {f_status, f_day, f_month, f_year, f_leap};

  // decoupling queue between front and back
  dadd_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  assign q_status = dadd_pkg::status_t'(q_rdata[QW-1 -: 2]);
  assign q_day    = q_rdata[QW-3 -: DAY_W];
  assign q_month  = q_rdata[16:13];
  assign q_year   = q_rdata[12:1];
  assign q_leap   = q_rdata[0];

  // back end walks month by month, then works out the weekday
  dadd_back #(
    .DAY_W (DAY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_status  (q_status),
    .q_day     (q_day),
    .q_month   (q_month),
    .q_year    (q_year),
    .q_leap    (q_leap),
    .pop       (pop),
    .empty     (empty),
    .status    (status),
    .new_day   (new_day),
    .new_month (new_month),
    .new_year  (new_year),
    .weekday   (weekday)
  );

endmodule

// ===== rtl/dadd_checker.sv =====
`include "calendar_date_add_days_defines.svh"

module dadd_checker (
  input logic        clk,
  input logic        rst,
  input logic        pop,
  input logic        empty,
  input logic [1:0]  status,
  input logic [4:0]  new_day,
  input logic [3:0]  new_month,
  input logic [2:0]  weekday
);

  // reset leaves nothing to pop
  `DADD_ASSERT_NEXT(a_reset_empty, rst, empty)

  // a rejected request never carries a weekday
  `DADD_ASSERT_NOW(a_reject_weekday, !empty && status != 2'd0, weekday == 3'd0)

  // a good advance lands on a real date and weekday
  `DADD_ASSERT_NOW(a_ok_range, !empty && status == 2'd0, new_day != 5'd0 && new_month != 4'd0 && new_month <= 4'd12 && weekday <= 3'd6)

  // a stalled result holds
  `DADD_ASSERT_NEXT(a_stall_hold, !rst && !empty && !pop, !empty && $stable(status) && $stable(new_day) && $stable(new_month))

endmodule

bind calendar_date_add_days dadd_checker u_dadd_checker (
  .clk       (clk),
  .rst       (rst),
  .pop       (pop),
  .empty     (empty),
  .status    (status),
  .new_day   (new_day),
  .new_month (new_month),
  .weekday   (weekday)
);

// ===== dv/calendar_date_add_days_test.sv =====
`timescale 1ns / 1ps

module calendar_date_add_days_test;

  // run length guard, far above the slowest legal run of this stimulus
  localparam int unsigned CYCLE_LIMIT = 3000000;
  // quiet cycles after the last result, to catch stray results
  localparam int DRAIN_CYCLES = 100;

  // one predicted result of a request
  typedef struct {
    dadd_pkg::status_t status;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [11:0]       year;
    logic [2:0]        weekday;
  } date_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [4:0]  start_day = '0;
  logic [3:0]  start_month = '0;
  logic [11:0] start_year = '0;
  logic [15:0] days_to_add = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  status;
  logic [4:0]  new_day;
  logic [3:0]  new_month;
  logic [11:0] new_year;
  logic [2:0]  weekday;

  // results predicted at request time, oldest first
  date_result_t predicted_dates[$];
  int           mismatch_count = 0;
  // random waits on both sides when set, back to back when clear
  bit           idle_enable = 1'b0;

  calendar_date_add_days uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .days_to_add (days_to_add),
    .pop         (pop),
    .empty       (empty),
    .status      (status),
    .new_day     (new_day),
    .new_month   (new_month),
    .new_year    (new_year),
    .weekday     (weekday)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // date arithmetic used for prediction
  // ---------------------------------------------------------------------------

  // gregorian leap rule
  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int y, int m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // division rounding toward minus infinity
  function automatic int floor_quot(int a, int b);
    int q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  // remainder that is never negative
  function automatic int nonneg_mod(int a, int b);
    int r;
    r = a % b;
    if (r < 0) r += b;
    return r;
  endfunction

  // full behavior of one request: check, advance month by month, weekday
  function automatic date_result_t advance_date(logic [4:0] d, logic [3:0] m,
                                                logic [11:0] y, logic [15:0] n);
    date_result_t r;
    int day;
    int mon;
    int yr;
    int hm;
    int hy;
    int k;
    int j;
    int s;
    r.status  = dadd_pkg::ST_OK;
    r.day     = d;
    r.month   = m;
    r.year    = y;
    r.weekday = '0;
    // a bad date wins over a zero count
    if (y > dadd_pkg::MAX_YEAR || m < 1 || m > dadd_pkg::MONTHS || d < 1 ||
        d > days_in_month(y, m)) begin
      r.status = dadd_pkg::ST_BAD_DATE;
    end else if (n == 0) begin
      r.status = dadd_pkg::ST_ZERO;
    end else begin
      day = int'(d) + int'(n);
      mon = m;
      yr  = y;
      while (day > days_in_month(yr, mon)) begin
        day -= days_in_month(yr, mon);
        mon++;
        if (mon > dadd_pkg::MONTHS) begin
          mon = 1;
          // year kept in 12 bits
          yr = (yr + 1) % 4096;
        end
      end
      // zeller: january and february belong to the year before, which is
      // -1 for year 0, so floor division and a non-negative modulo
      hm = mon;
      hy = yr;
      if (hm < 3) begin
        hm += 12;
        hy -= 1;
      end
      k = nonneg_mod(hy, 100);
      j = floor_quot(hy, 100);
      s = day + (13 * (hm + 1)) / 5 + k + k / 4 + floor_quot(j, 4) + 5 * j;
      r.day     = 5'(day);
      r.month   = 4'(mon);
      r.year    = 12'(yr);
      r.weekday = 3'(nonneg_mod(s, 7));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // present one request from a falling edge and hold it until taken;
  // returns at the falling edge after the accepting rising edge
  task automatic send_request(logic [4:0] d, logic [3:0] m, logic [11:0] y,
                              logic [15:0] n);
    int wait_cycles;
    wait_cycles = idle_enable ? $urandom_range(0, 5) : 0;
    if (wait_cycles > 0) begin
      push <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    push        <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    days_to_add <= n;
    // full is read at the edge, before the block updates it
    do @(posedge clk); while (full);
    predicted_dates.push_back(advance_date(d, m, y, n));
    @(negedge clk);
  endtask

  // random date that passes the check, with the extreme years favored
  task automatic draw_valid_date(output logic [4:0] d, output logic [3:0] m,
                                 output logic [11:0] y);
    int yr;
    int mon;
    int len;
    case ($urandom_range(0, 9))
      0:       yr = 0;
      1:       yr = dadd_pkg::MAX_YEAR;
      2: begin
        case ($urandom_range(0, 3))
          0:       yr = 1900;
          1:       yr = 2000;
          2:       yr = 1600;
          default: yr = 4 * $urandom_range(0, 525);
        endcase
      end
      default: yr = $urandom_range(0, dadd_pkg::MAX_YEAR);
    endcase
    mon = $urandom_range(1, dadd_pkg::MONTHS);
    len = days_in_month(yr, mon);
    // month ends are where the stepping turns over
    d = ($urandom_range(0, 4) == 0) ? 5'(len) : 5'($urandom_range(1, len));
    m = 4'(mon);
    y = 12'(yr);
  endtask

  // day count, mostly short so the month loop stays cheap
  function automatic logic [15:0] draw_count();
    case ($urandom_range(0, 19))
      0, 1:    return 16'($urandom_range(1, 65535));
      2:       return 16'($urandom_range(1, 3));
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: random stall per result, then pop until one is taken
  initial begin : result_drain
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_enable ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  task automatic check_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // each result taken is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    date_result_t exp_r;
    if (!rst && pop && !empty) begin
      if (predicted_dates.size() == 0) begin
        $display("%0t: result with no request waiting, status %0d date %0d/%0d/%0d",
                 $time, status, new_day, new_month, new_year);
        mismatch_count++;
      end else begin
        exp_r = predicted_dates.pop_front();
        check_field("status", 12'(exp_r.status), 12'(status));
        check_field("new_day", 12'(exp_r.day), 12'(new_day));
        check_field("new_month", 12'(exp_r.month), 12'(new_month));
        check_field("new_year", exp_r.year, new_year);
        check_field("weekday", 12'(exp_r.weekday), 12'(weekday));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // widest fields and the longest advances
  task automatic test_field_extremes();
    send_request(5'd31, 4'd12, 12'd2100, 16'hFFFF);
    send_request(5'd1, 4'd1, 12'd0, 16'hFFFF);
    send_request(5'd31, 4'd15, 12'd4095, 16'hFFFF);
    send_request(5'd1, 4'd1, 12'd2100, 16'd1);
  endtask

  // bad dates of every kind, zero count, and both faults at once
  task automatic test_rejected_requests();
    send_request(5'd0, 4'd5, 12'd2000, 16'd5);       // day zero
    send_request(5'd31, 4'd4, 12'd2000, 16'd5);      // past a 30-day month
    send_request(5'd15, 4'd0, 12'd2000, 16'd5);      // month zero
    send_request(5'd15, 4'd13, 12'd2000, 16'd5);     // month past december
    send_request(5'd1, 4'd1, 12'd2101, 16'd5);       // year past the limit
    send_request(5'd31, 4'd2, 12'd2020, 16'd0);      // bad date and zero count
    send_request(5'd10, 4'd10, 12'd2010, 16'd0);     // zero count only
    send_request(5'd1, 4'd1, 12'd2100, 16'd0);
  endtask

  // february of leap and non-leap centuries, month and year rollover
  task automatic test_leap_and_rollover();
    send_request(5'd29, 4'd2, 12'd2000, 16'd1);
    send_request(5'd29, 4'd2, 12'd1900, 16'd1);      // 1900 is not leap
    send_request(5'd29, 4'd2, 12'd2100, 16'd1);      // nor is 2100
    send_request(5'd28, 4'd2, 12'd2100, 16'd1);
    send_request(5'd31, 4'd12, 12'd1999, 16'd1);
    send_request(5'd31, 4'd1, 12'd2023, 16'd28);
    send_request(5'd30, 4'd6, 12'd2024, 16'd1);
    send_request(5'd1, 4'd3, 12'd2000, 16'd365);
  endtask

  // january and february of year 0 reach back to year -1 for the weekday, of year 1 to year 0
  task automatic test_year_zero_weekday();
    send_request(5'd1, 4'd1, 12'd0, 16'd1);
    send_request(5'd28, 4'd2, 12'd0, 16'd1);
    send_request(5'd31, 4'd12, 12'd0, 16'd59);
  endtask

  // well-formed requests with random content and random waits
  task automatic test_random_advances(int count);
    logic [4:0]  d;
    logic [3:0]  m;
    logic [11:0] y;
    idle_enable = 1'b1;
    repeat (count) begin
      draw_valid_date(d, m, y);
      send_request(d, m, y, draw_count());
    end
  endtask

  // same, with both sides running flat out
  task automatic test_back_to_back(int count);
    logic [4:0]  d;
    logic [3:0]  m;
    logic [11:0] y;
    idle_enable = 1'b0;
    repeat (count) begin
      draw_valid_date(d, m, y);
      send_request(d, m, y, ($urandom_range(0, 3) == 0) ? 16'd1 : draw_count());
    end
  endtask

  // raw fields, zero counts and dates broken in one field
  task automatic test_random_noise(int count);
    logic [4:0]  d;
    logic [3:0]  m;
    logic [11:0] y;
    logic [15:0] n;
    int          len;
    idle_enable = 1'b1;
    repeat (count) begin
      draw_valid_date(d, m, y);
      n = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0: begin
          d = 5'($urandom_range(0, 31));
          m = 4'($urandom_range(0, 15));
          y = 12'($urandom_range(0, 4095));
        end
        1: n = '0;
        2: begin
          len = days_in_month(y, m);
          d = (len == 31) ? 5'd0 : 5'($urandom_range(len + 1, 31));
        end
        default: y = 12'($urandom_range(dadd_pkg::MAX_YEAR + 1, 4095));
      endcase
      send_request(d, m, y, n);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    // synchronous reset, released on a falling edge
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_enable = 1'b1;
    test_field_extremes();
    test_rejected_requests();
    test_leap_and_rollover();
    test_year_zero_weekday();
    test_random_advances(150);
    test_back_to_back(40);
    test_random_noise(40);

    push <= 1'b0;
    // all results in, then a quiet stretch for anything extra
    wait (predicted_dates.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, predicted_dates.size());
    $display("Verification failed");
    $finish;
  end

endmodule
